// ===== src/gwf_pkg.sv =====
// ----------------------------------------------------------------------------
// gwf_pkg
// Shared types, codes and helpers for the grid wall follower collector.
// ----------------------------------------------------------------------------
package gwf_pkg;

  typedef logic [1:0] cell_t;

  localparam cell_t CELL_FREE = 2'd0;
  localparam cell_t CELL_WALL = 2'd1;
  localparam cell_t CELL_COIN = 2'd2;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_PLACE = 2'd2;

  localparam logic [1:0] HEAD_RIGHT = 2'd0;
  localparam logic [1:0] HEAD_DOWN  = 2'd1;
  localparam logic [1:0] HEAD_LEFT  = 2'd2;
  localparam logic [1:0] HEAD_UP    = 2'd3;

  localparam logic [1:0] CFG_START_ROW = 2'd0;
  localparam logic [1:0] CFG_START_COL = 2'd1;
  localparam logic [1:0] CFG_EXIT_ROW  = 2'd2;
  localparam logic [1:0] CFG_EXIT_COL  = 2'd3;

  localparam logic [3:0] RST_ROW       = 4'd1;
  localparam logic [3:0] RST_COL       = 4'd1;
  localparam logic [3:0] RST_START_ROW = 4'd1;
  localparam logic [3:0] RST_START_COL = 4'd1;
  localparam logic [3:0] RST_EXIT_ROW  = 4'd4;
  localparam logic [3:0] RST_EXIT_COL  = 4'd4;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // Bank word address width: a bank holds one parity class, eight cells per row.
  localparam int BANK_ADDR_FULL = 7;

  typedef struct packed {
    logic [3:0] row;
    logic [3:0] col;
  } cell_pos_t;

  typedef struct packed {
    logic      en;
    cell_pos_t pos;
    cell_t     data;
  } wr_req_t;

  typedef struct packed {
    cell_pos_t cur;
    cell_pos_t rgt;
    cell_pos_t fwd;
  } rd_req_t;

  typedef struct packed {
    logic [3:0] start_row;
    logic [3:0] start_col;
    logic [3:0] exit_row;
    logic [3:0] exit_col;
  } cfg_t;

  typedef struct packed {
    logic        at_exit;
    logic        coin_taken;
    logic [15:0] coin_total;
    logic [1:0]  heading;
    logic [3:0]  walker_col;
    logic [3:0]  walker_row;
  } res_t;

  // Neighbor row; one above row zero wraps to a large value, i.e. outside.
  function automatic logic [4:0] nb_row(logic [3:0] r, logic [1:0] d);
    logic [4:0] r5;
    r5 = {1'b0, r};
    case (d)
      HEAD_DOWN: nb_row = r5 + 5'd1;
      HEAD_UP:   nb_row = r5 - 5'd1;
      default:   nb_row = r5;
    endcase
  endfunction

  function automatic logic [4:0] nb_col(logic [3:0] c, logic [1:0] d);
    logic [4:0] c5;
    c5 = {1'b0, c};
    case (d)
      HEAD_RIGHT: nb_col = c5 + 5'd1;
      HEAD_LEFT:  nb_col = c5 - 5'd1;
      default:    nb_col = c5;
    endcase
  endfunction

  // Checkerboard bank select and word address within the bank.
  function automatic logic cell_parity(cell_pos_t p);
    cell_parity = p.row[0] ^ p.col[0];
  endfunction

  function automatic logic [BANK_ADDR_FULL-1:0] bank_index(cell_pos_t p);
    bank_index = {p.row, p.col[3:1]};
  endfunction

endpackage

// ===== src/gwf_bank.sv =====
// ----------------------------------------------------------------------------
// gwf_bank
// One checkerboard half of the grid: one write port, two registered reads,
// per-entry valid bits so unwritten cells read as free after reset.
// ----------------------------------------------------------------------------
module gwf_bank
  import gwf_pkg::*;
#(
  parameter int AW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  cell_t         wr_data,
  input  logic [AW-1:0] rd_addr0,
  input  logic [AW-1:0] rd_addr1,
  output cell_t         rd_data0,
  output cell_t         rd_data1
);

  localparam int DEPTH = 1 << AW;

  cell_t            mem [DEPTH];
  logic [DEPTH-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // Write-first: a read of the cell written this cycle returns the new value.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_data0 <= CELL_FREE;
      rd_data1 <= CELL_FREE;
    end else begin
      if (wr_en && wr_addr == rd_addr0) begin
        rd_data0 <= wr_data;
      end else if (valid[rd_addr0]) begin
        rd_data0 <= mem[rd_addr0];
      end else begin
        rd_data0 <= CELL_FREE;
      end
      if (wr_en && wr_addr == rd_addr1) begin
        rd_data1 <= wr_data;
      end else if (valid[rd_addr1]) begin
        rd_data1 <= mem[rd_addr1];
      end else begin
        rd_data1 <= CELL_FREE;
      end
    end
  end

endmodule

// ===== src/gwf_walker.sv =====
// ----------------------------------------------------------------------------
// gwf_walker
// Walker state and one item's update: load, right-hand step, place. Drives
// the grid write and the cell reads for the position it moves to.
// ----------------------------------------------------------------------------
module gwf_walker
  import gwf_pkg::*;
#(
  parameter int ROWS_EFF = 16,
  parameter int COLS_EFF = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  logic [1:0] opcode,
  input  logic [3:0] cell_row,
  input  logic [3:0] cell_col,
  input  cell_t      cell_value,
  input  cfg_t       cfg,
  input  cell_t      cur_cell,
  input  cell_t      rgt_cell,
  input  cell_t      fwd_cell,
  output wr_req_t    wr,
  output rd_req_t    rd,
  output res_t       res
);

  localparam logic [4:0] ROW_LIM = 5'(ROWS_EFF);
  localparam logic [4:0] COL_LIM = 5'(COLS_EFF);

  logic [3:0]  pos_row, pos_row_next;
  logic [3:0]  pos_col, pos_col_next;
  logic [1:0]  heading, heading_next;
  logic [15:0] coin_count, coin_count_next;

  logic [1:0]  rgt_dir, rgt_dir_next;
  logic [4:0]  rr5, rc5, fr5, fc5;
  logic        cur_in, rgt_clear, fwd_clear, on_exit, take;

  function automatic logic in_grid(logic [4:0] r, logic [4:0] c);
    in_grid = (r < ROW_LIM) && (c < COL_LIM);
  endfunction

  always_comb begin
    rgt_dir   = heading + 2'd1;
    rr5       = nb_row(pos_row, rgt_dir);
    rc5       = nb_col(pos_col, rgt_dir);
    fr5       = nb_row(pos_row, heading);
    fc5       = nb_col(pos_col, heading);
    cur_in    = in_grid({1'b0, pos_row}, {1'b0, pos_col});
    rgt_clear = in_grid(rr5, rc5) && rgt_cell != CELL_WALL;
    fwd_clear = in_grid(fr5, fc5) && fwd_cell != CELL_WALL;
    on_exit   = pos_row == cfg.exit_row && pos_col == cfg.exit_col;
    take      = (opcode == OP_STEP) && cur_in && cur_cell == CELL_COIN;
  end

  always_comb begin
    pos_row_next    = pos_row;
    pos_col_next    = pos_col;
    heading_next    = heading;
    coin_count_next = coin_count;
    wr.en           = 1'b0;
    wr.pos.row      = cell_row;
    wr.pos.col      = cell_col;
    wr.data         = cell_value;
    if (in_fire) begin
      case (opcode)
        OP_LOAD: begin
          wr.en = in_grid({1'b0, cell_row}, {1'b0, cell_col});
        end
        OP_STEP: begin
          if (take) begin
            // clear the coin under the walker
            wr.en      = 1'b1;
            wr.pos.row = pos_row;
            wr.pos.col = pos_col;
            wr.data    = CELL_FREE;
            if (coin_count != COUNT_MAX) begin
              coin_count_next = coin_count + 16'd1;
            end
          end
          if (!on_exit) begin
            if (rgt_clear) begin
              heading_next = rgt_dir;
              pos_row_next = rr5[3:0];
              pos_col_next = rc5[3:0];
            end else if (fwd_clear) begin
              pos_row_next = fr5[3:0];
              pos_col_next = fc5[3:0];
            end else begin
              heading_next = heading + 2'd3;
            end
          end
        end
        OP_PLACE: begin
          pos_row_next    = cfg.start_row;
          pos_col_next    = cfg.start_col;
          heading_next    = HEAD_RIGHT;
          coin_count_next = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_row    <= RST_ROW;
      pos_col    <= RST_COL;
      heading    <= HEAD_RIGHT;
      coin_count <= '0;
    end else begin
      pos_row    <= pos_row_next;
      pos_col    <= pos_col_next;
      heading    <= heading_next;
      coin_count <= coin_count_next;
    end
  end

  // Fetch the cells around the position held next cycle.
  always_comb begin
    rgt_dir_next = heading_next + 2'd1;
    rd.cur.row   = pos_row_next;
    rd.cur.col   = pos_col_next;
    rd.rgt.row   = 4'(nb_row(pos_row_next, rgt_dir_next));
    rd.rgt.col   = 4'(nb_col(pos_col_next, rgt_dir_next));
    rd.fwd.row   = 4'(nb_row(pos_row_next, heading_next));
    rd.fwd.col   = 4'(nb_col(pos_col_next, heading_next));
  end

  always_comb begin
    res.walker_row = pos_row_next;
    res.walker_col = pos_col_next;
    res.heading    = heading_next;
    res.coin_total = coin_count_next;
    res.coin_taken = take;
    res.at_exit    = pos_row_next == cfg.exit_row && pos_col_next == cfg.exit_col;
  end

endmodule

// ===== src/grid_wall_follower_collector_top.sv =====
// ----------------------------------------------------------------------------
// grid_wall_follower_collector_top
// Grid map walker following the right-hand wall rule and collecting coins.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake          Payload
//  s_*      in   s_tvalid/s_tready  tuser: opcode; tdata: row, col, value
//  m_*      out  m_tvalid/m_tready  tdata: walker state after the request
//  cfg_*    in   cfg_wr_en          cfg_index, cfg_wdata
//
//  One request per cycle while the output is not stalled; its result is valid the cycle after acceptance.
//  The grid sits in two checkerboard banks whose registered reads always
//  hold the current, right and front cells of the walker, refetched each
//  cycle from the next position.
//  Reset clears walker, config and grid valid bits.
//  A stalled result holds the output register and blocks new requests.
// ----------------------------------------------------------------------------
module grid_wall_follower_collector_top
  import gwf_pkg::*;
#(
  parameter int GRID_ROWS = 16,
  parameter int GRID_COLS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  input  logic [15:0] s_tdata,   // [3:0] cell_row, [7:4] cell_col, [9:8] cell_value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [3:0] walker_row, [7:4] walker_col, [9:8] heading,
                                 // [25:10] coin_total, [26] coin_taken, [27] at_exit
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_wdata
);

  localparam int ROWS_EFF = (GRID_ROWS < 16) ? GRID_ROWS : 16;
  localparam int COLS_EFF = (GRID_COLS < 16) ? GRID_COLS : 16;
  localparam int AW       = $clog2(ROWS_EFF * 8);

  cfg_t    cfg;
  wr_req_t wr;
  rd_req_t rd;
  res_t    res, res_q;
  logic    in_fire;
  logic    rd_par, rd_par_q, wr_par;
  cell_t   b0_rd0, b0_rd1, b1_rd0, b1_rd1;
  cell_t   cur_cell, rgt_cell, fwd_cell;

  logic [BANK_ADDR_FULL-1:0] cur_idx, rgt_idx, fwd_idx, wr_idx;

  assign s_tready = !rst && (!m_tvalid || m_tready);
  assign in_fire  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_row <= RST_START_ROW;
      cfg.start_col <= RST_START_COL;
      cfg.exit_row  <= RST_EXIT_ROW;
      cfg.exit_col  <= RST_EXIT_COL;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_START_ROW: cfg.start_row <= cfg_wdata;
        CFG_START_COL: cfg.start_col <= cfg_wdata;
        CFG_EXIT_ROW:  cfg.exit_row  <= cfg_wdata;
        CFG_EXIT_COL:  cfg.exit_col  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  gwf_walker #(
    .ROWS_EFF (ROWS_EFF),
    .COLS_EFF (COLS_EFF)
  ) u_walker (
    .clk        (clk),
    .rst        (rst),
    .in_fire    (in_fire),
    .opcode     (s_tuser),
    .cell_row   (s_tdata[3:0]),
    .cell_col   (s_tdata[7:4]),
    .cell_value (s_tdata[9:8]),
    .cfg        (cfg),
    .cur_cell   (cur_cell),
    .rgt_cell   (rgt_cell),
    .fwd_cell   (fwd_cell),
    .wr         (wr),
    .rd         (rd),
    .res        (res)
  );

  // The walker's cell is in one bank, both neighbors in the other.
  always_comb begin
    rd_par  = cell_parity(rd.cur);
    wr_par  = cell_parity(wr.pos);
    cur_idx = bank_index(rd.cur);
    rgt_idx = bank_index(rd.rgt);
    fwd_idx = bank_index(rd.fwd);
    wr_idx  = bank_index(wr.pos);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_par_q <= RST_ROW[0] ^ RST_COL[0];
    end else begin
      rd_par_q <= rd_par;
    end
  end

  gwf_bank #(.AW(AW)) u_bank0 (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr.en && !wr_par),
    .wr_addr  (wr_idx[AW-1:0]),
    .wr_data  (wr.data),
    .rd_addr0 (rd_par ? rgt_idx[AW-1:0] : cur_idx[AW-1:0]),
    .rd_addr1 (rd_par ? fwd_idx[AW-1:0] : cur_idx[AW-1:0]),
    .rd_data0 (b0_rd0),
    .rd_data1 (b0_rd1)
  );

  gwf_bank #(.AW(AW)) u_bank1 (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr.en && wr_par),
    .wr_addr  (wr_idx[AW-1:0]),
    .wr_data  (wr.data),
    .rd_addr0 (rd_par ? cur_idx[AW-1:0] : rgt_idx[AW-1:0]),
    .rd_addr1 (rd_par ? cur_idx[AW-1:0] : fwd_idx[AW-1:0]),
    .rd_data0 (b1_rd0),
    .rd_data1 (b1_rd1)
  );

  always_comb begin
    cur_cell = rd_par_q ? b1_rd0 : b0_rd0;
    rgt_cell = rd_par_q ? b0_rd0 : b1_rd0;
    fwd_cell = rd_par_q ? b0_rd1 : b1_rd1;
  end

  // Output register: load on accept, hold while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_q <= res;
    end
  end

  assign m_tdata = {4'b0, res_q};

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the grid wall follower collector. A walker model
// in the bench tracks the grid, position, heading and coin count for every
// accepted request. Each returned walker state is compared against it field
// by field. Directed moves and coin pickup on the exit run with no idles or stalls;
// random maze walks run under several sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
module tb_top
  import gwf_pkg::*;
();

  localparam int GRID_ROWS = 16;
  localparam int GRID_COLS = 16;
  localparam logic [1:0] OP_NONE   = 2'd3;
  localparam logic [1:0] CELL_ODD  = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [1:0]  s_tuser = '0;   // [1:0] opcode
  logic [15:0] s_tdata = '0;   // [3:0] cell_row, [7:4] cell_col, [9:8] cell_value
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [3:0] walker_row, [7:4] walker_col, [9:8] heading,
                               // [25:10] coin_total, [26] coin_taken, [27] at_exit
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [3:0]  cfg_wdata = '0;

  grid_wall_follower_collector_top #(
    .GRID_ROWS(GRID_ROWS),
    .GRID_COLS(GRID_COLS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser(s_tuser),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Walker model state
  logic [1:0]  map_cells [256];
  logic [3:0]  walker_row, walker_col;
  logic [1:0]  walker_heading;
  logic [15:0] coins_held;
  logic [3:0]  start_row_q, start_col_q, exit_row_q, exit_col_q;

  res_t pending_walker_states[$];
  int   error_count = 0;
  int   sender_idle_pct = 0;
  int   receiver_stall_pct = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int head_dr(logic [1:0] h);
    case (h)
      HEAD_DOWN: return 1;
      HEAD_UP:   return -1;
      default:   return 0;
    endcase
  endfunction

  function automatic int head_dc(logic [1:0] h);
    case (h)
      HEAD_RIGHT: return 1;
      HEAD_LEFT:  return -1;
      default:    return 0;
    endcase
  endfunction

  // Anything off the map reads as wall.
  function automatic logic [1:0] map_lookup(int r, int c);
    if (r < 0 || c < 0 || r >= GRID_ROWS || c >= GRID_COLS || r > 15 || c > 15)
      return CELL_WALL;
    return map_cells[r * 16 + c];
  endfunction

  function automatic logic path_clear(logic [1:0] h);
    return map_lookup(int'(walker_row) + head_dr(h),
                      int'(walker_col) + head_dc(h)) != CELL_WALL;
  endfunction

  function automatic void walk_forward();
    walker_row = walker_row + 4'(head_dr(walker_heading));
    walker_col = walker_col + 4'(head_dc(walker_heading));
  endfunction

  function automatic res_t predict_walker(logic [1:0] op, logic [3:0] row, logic [3:0] col,
                                          logic [1:0] val);
    res_t       r;
    logic       on_exit;
    logic       taken;
    logic [1:0] turn;
    taken = 1'b0;
    case (op)
      OP_LOAD: begin
        if (row < GRID_ROWS && col < GRID_COLS)
          map_cells[{row, col}] = val;
      end
      OP_STEP: begin
        on_exit = walker_row == exit_row_q && walker_col == exit_col_q;
        if (walker_row < GRID_ROWS && walker_col < GRID_COLS &&
            map_cells[{walker_row, walker_col}] == CELL_COIN) begin
          map_cells[{walker_row, walker_col}] = CELL_FREE;
          taken = 1'b1;
          if (coins_held != COUNT_MAX)
            coins_held = coins_held + 16'd1;
        end
        if (!on_exit) begin
          turn = walker_heading + 2'd1;
          if (path_clear(turn)) begin
            walker_heading = turn;
            walk_forward();
          end else if (path_clear(walker_heading)) begin
            walk_forward();
          end else begin
            walker_heading = walker_heading - 2'd1;
          end
        end
      end
      OP_PLACE: begin
        walker_row     = start_row_q;
        walker_col     = start_col_q;
        walker_heading = HEAD_RIGHT;
        coins_held     = '0;
      end
      default: ;
    endcase
    r.walker_row = walker_row;
    r.walker_col = walker_col;
    r.heading    = walker_heading;
    r.coin_total = coins_held;
    r.coin_taken = taken;
    r.at_exit    = walker_row == exit_row_q && walker_col == exit_col_q;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Result checker
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      got = m_tdata[27:0];
      if (pending_walker_states.size() == 0) begin
        $error("walker state returned with no request pending: %h", m_tdata);
        error_count++;
      end else begin
        want = pending_walker_states.pop_front();
        check_field("walker_row", want.walker_row, got.walker_row);
        check_field("walker_col", want.walker_col, got.walker_col);
        check_field("heading", want.heading, got.heading);
        check_field("coin_total", want.coin_total, got.coin_total);
        check_field("coin_taken", want.coin_taken, got.coin_taken);
        check_field("at_exit", want.at_exit, got.at_exit);
      end
    end
  end

  always @(negedge clk) begin
    m_tready <= $urandom_range(0, 99) >= receiver_stall_pct;
  end

  task automatic send_request(logic [1:0] op, logic [3:0] row, logic [3:0] col,
                              logic [1:0] val);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {6'b0, val, col, row};
    do @(posedge clk); while (!s_tready);
    pending_walker_states.push_back(predict_walker(op, row, col, val));
  endtask

  // Hold off the sender until every pending walker state has come back.
  task automatic wait_quiet();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_walker_states.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [3:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_START_ROW: start_row_q = val;
      CFG_START_COL: start_col_q = val;
      CFG_EXIT_ROW:  exit_row_q  = val;
      default:       exit_col_q  = val;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_start_exit(logic [3:0] sr, logic [3:0] sc, logic [3:0] er,
                                logic [3:0] ec);
    wait_quiet();
    write_register(CFG_START_ROW, sr);
    write_register(CFG_START_COL, sc);
    write_register(CFG_EXIT_ROW, er);
    write_register(CFG_EXIT_COL, ec);
  endtask

  task automatic test_directed_moves();
    // Step straight out of reset on an empty map, then an unused opcode.
    send_request(OP_STEP, 4'd0, 4'd0, CELL_FREE);
    send_request(OP_NONE, 4'hF, 4'hF, CELL_ODD);
    // Corner loads with every cell code
    send_request(OP_LOAD, 4'd0, 4'd0, CELL_ODD);
    send_request(OP_LOAD, 4'hF, 4'hF, CELL_COIN);
    send_request(OP_LOAD, 4'd0, 4'hF, CELL_WALL);
    send_request(OP_LOAD, 4'hF, 4'd0, CELL_FREE);
    // Coin under the start cell, then walker standing on a wall
    send_request(OP_LOAD, 4'd1, 4'd1, CELL_COIN);
    send_request(OP_PLACE, 4'd0, 4'd0, CELL_FREE);
    send_request(OP_STEP, 4'd0, 4'd0, CELL_FREE);
    send_request(OP_LOAD, 4'd1, 4'd1, CELL_WALL);
    send_request(OP_PLACE, 4'd0, 4'd0, CELL_FREE);
    send_request(OP_STEP, 4'd0, 4'd0, CELL_FREE);
    // Bottom-right corner: right and front are off the map, so turn left.
    set_start_exit(4'hF, 4'hF, 4'd0, 4'd0);
    send_request(OP_PLACE, 4'd0, 4'd0, CELL_FREE);
    send_request(OP_STEP, 4'd0, 4'd0, CELL_FREE);
    send_request(OP_STEP, 4'd0, 4'd0, CELL_FREE);
    // Start on the exit: steps only pick up the coin.
    set_start_exit(4'd0, 4'd0, 4'd0, 4'd0);
    send_request(OP_PLACE, 4'd0, 4'd0, CELL_FREE);
    send_request(OP_LOAD, 4'd0, 4'd0, CELL_COIN);
    send_request(OP_STEP, 4'd0, 4'd0, CELL_FREE);
    send_request(OP_STEP, 4'd0, 4'd0, CELL_FREE);
    // Code three reads as free; left of column zero reads as wall.
    set_start_exit(4'd0, 4'd0, 4'd4, 4'd4);
    send_request(OP_LOAD, 4'd1, 4'd0, CELL_ODD);
    send_request(OP_PLACE, 4'd0, 4'd0, CELL_FREE);
    send_request(OP_STEP, 4'd0, 4'd0, CELL_FREE);
    send_request(OP_STEP, 4'd0, 4'd0, CELL_FREE);
    // Right blocked, front open: move forward.
    send_request(OP_LOAD, 4'd1, 4'd0, CELL_WALL);
    send_request(OP_PLACE, 4'd0, 4'd0, CELL_FREE);
    send_request(OP_STEP, 4'd0, 4'd0, CELL_FREE);
  endtask

  // Park the walker on the exit and feed it coins back to back.
  task automatic test_coin_pickup();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    set_start_exit(4'd7, 4'd7, 4'd7, 4'd7);
    send_request(OP_PLACE, 4'd0, 4'd0, CELL_FREE);
    for (int i = 0; i < 8; i++) begin
      send_request(OP_LOAD, 4'd7, 4'd7, CELL_COIN);
      send_request(OP_STEP, 4'd0, 4'd0, CELL_FREE);
    end
    send_request(OP_PLACE, 4'd0, 4'd0, CELL_FREE);
  endtask

  task automatic test_random_walks(int idle_pct, int stall_pct, logic [3:0] sr,
                                   logic [3:0] sc, logic [3:0] er, logic [3:0] ec,
                                   int count);
    int         pick;
    int         wpick;
    logic [3:0] row;
    logic [3:0] col;
    logic [1:0] val;
    set_start_exit(sr, sc, er, ec);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    send_request(OP_PLACE, 4'($urandom), 4'($urandom), 2'($urandom));
    for (int i = 0; i < count; i++) begin
      if (i == count / 2)
        wait_quiet();
      pick  = $urandom_range(0, 99);
      wpick = $urandom_range(0, 99);
      row   = 4'($urandom);
      col   = 4'($urandom);
      val   = wpick < 40 ? CELL_WALL : wpick < 65 ? CELL_COIN :
              wpick < 90 ? CELL_FREE : CELL_ODD;
      if (pick < 55) begin
        send_request(OP_STEP, row, col, 2'($urandom));
      end else if (pick < 85) begin
        // Mostly build walls and coins around where the walker stands.
        if ($urandom_range(0, 99) < 70) begin
          row = walker_row + 4'($urandom_range(0, 4)) - 4'd2;
          col = walker_col + 4'($urandom_range(0, 4)) - 4'd2;
        end
        send_request(OP_LOAD, row, col, val);
      end else if (pick < 92) begin
        send_request(OP_PLACE, row, col, val);
      end else if (pick < 96) begin
        send_request(OP_NONE, row, col, val);
      end else begin
        send_request(2'($urandom), row, col, 2'($urandom));
      end
    end
  endtask

  initial begin
    foreach (map_cells[i]) map_cells[i] = CELL_FREE;
    walker_row     = RST_ROW;
    walker_col     = RST_COL;
    walker_heading = HEAD_RIGHT;
    coins_held     = '0;
    start_row_q    = RST_START_ROW;
    start_col_q    = RST_START_COL;
    exit_row_q     = RST_EXIT_ROW;
    exit_col_q     = RST_EXIT_COL;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_moves();
    test_coin_pickup();
    test_random_walks(0, 0, 4'd0, 4'd0, 4'hF, 4'hF, 90);
    test_random_walks(67, 0, 4'hF, 4'hF, 4'd0, 4'd0, 90);
    test_random_walks(0, 67, 4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom), 90);
    test_random_walks(21, 21, 4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom), 90);

    wait_quiet();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
